// ===== rtl/core/i2c_master_transaction_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// I2C master sequencer assertion macros
// Shared property forms for the sequencer checker.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define I2CM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define I2CM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master sequencer package
// Beat types, operation and event codes, phase codes and defaults.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   localparam int BUF_DEPTH_DEF = 32;

   localparam logic [7:0] ATTEMPT_LIMIT_RST = 8'd10;
   localparam logic [7:0] ADDR_WR_MASK      = 8'hFE;

   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ATTEMPT_LIMIT = 2'd0;

   // commands
   localparam logic [1:0] CMD_BEGIN_WR = 2'd0;
   localparam logic [1:0] CMD_BEGIN_RD = 2'd1;
   localparam logic [1:0] CMD_EVENT    = 2'd2;
   localparam logic [1:0] CMD_LOAD     = 2'd3;

   // bus events
   localparam logic [2:0] EV_ADDR_ACK  = 3'd1;
   localparam logic [2:0] EV_ADDR_NACK = 3'd2;
   localparam logic [2:0] EV_DATA_ACK  = 3'd3;
   localparam logic [2:0] EV_ARB_LOST  = 3'd5;

   // bus operations
   localparam logic [2:0] OP_NONE   = 3'd0;
   localparam logic [2:0] OP_START  = 3'd1;
   localparam logic [2:0] OP_ADDR   = 3'd2;
   localparam logic [2:0] OP_DATA   = 3'd3;
   localparam logic [2:0] OP_RXACK  = 3'd4;
   localparam logic [2:0] OP_RXNACK = 3'd5;
   localparam logic [2:0] OP_STOP   = 3'd6;

   // result codes
   localparam logic [1:0] RES_OK        = 2'd0;
   localparam logic [1:0] RES_NO_SLAVE  = 2'd1;
   localparam logic [1:0] RES_EXHAUSTED = 2'd2;

   // phases
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_START = 3'd1;
   localparam logic [2:0] PH_ADDR  = 3'd2;
   localparam logic [2:0] PH_DATA  = 3'd3;
   localparam logic [2:0] PH_RX    = 3'd4;
   localparam logic [2:0] PH_LAST  = 3'd5;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] address;
      logic [5:0] length;
      logic [2:0] event_req;
      logic [7:0] rx_byte;
      logic [4:0] load_index;
      logic [7:0] load_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] bus_op;
      logic [7:0] tx_byte;
      logic       store_valid;
      logic [4:0] store_index;
      logic [7:0] store_byte;
      logic       done_res;
      logic [1:0] result_code;
   } rsp_type;

   // result of one step plus the buffer read it needs
   typedef struct packed {
      rsp_type rsp;
      logic    use_buf;
   } step_type;

endpackage

// ===== rtl/core/i2cm_wbuf.sv =====
// ----------------------------------------------------------------------------
// I2C master write buffer
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module i2cm_wbuf #(
   parameter int DEPTH = i2cm_pkg::BUF_DEPTH_DEF,
   parameter int AW    = 5
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/i2cm_ctrl.sv =====
// ----------------------------------------------------------------------------
// I2C master sequencer control
// Transfer state and next bus operation for one beat.
// ----------------------------------------------------------------------------
module i2cm_ctrl #(
   parameter int BUF_DEPTH = i2cm_pkg::BUF_DEPTH_DEF,
   parameter int AW        = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  i2cm_pkg::req_type   item,
   input  logic [7:0]          attempt_limit,
   output i2cm_pkg::step_type  step,
   output logic                buf_wr_en,
   output logic [AW-1:0]       buf_wr_addr,
   output logic                buf_rd_en,
   output logic [AW-1:0]       buf_rd_addr
);

   localparam int PW = (AW > 6) ? AW : 6;

   logic [2:0] phase_ff, phase_in;
   logic       is_read_ff, is_read_in;
   logic [7:0] slave_ff, slave_in;
   logic [5:0] xfer_len_ff, xfer_len_in;
   logic [5:0] byte_pos_ff, byte_pos_in;
   logic [7:0] attempts_ff, attempts_in;

   logic          do_retry, do_nread, do_nwrite, fin, fin_stop;
   logic [1:0]    fin_code;
   logic [5:0]    next_pos;
   logic [PW-1:0] pos_ext, li_ext;
   logic          arb;

   assign arb     = (item.event_req == i2cm_pkg::EV_ARB_LOST);
   assign pos_ext = PW'(next_pos);
   assign li_ext  = PW'(item.load_index);

   always_comb begin
      phase_in    = phase_ff;
      is_read_in  = is_read_ff;
      slave_in    = slave_ff;
      xfer_len_in = xfer_len_ff;
      byte_pos_in = byte_pos_ff;
      attempts_in = attempts_ff;
      step        = '0;
      do_retry    = 1'b0;
      do_nread    = 1'b0;
      do_nwrite   = 1'b0;
      fin         = 1'b0;
      fin_stop    = 1'b0;
      fin_code    = i2cm_pkg::RES_OK;
      next_pos    = byte_pos_ff;
      buf_wr_en   = 1'b0;
      buf_rd_en   = 1'b0;

      unique case (item.cmd) inside
         i2cm_pkg::CMD_LOAD: begin
            buf_wr_en = adv && (int'(item.load_index) < BUF_DEPTH);
         end
         i2cm_pkg::CMD_BEGIN_WR, i2cm_pkg::CMD_BEGIN_RD: begin
            if (phase_ff == i2cm_pkg::PH_IDLE) begin
               is_read_in  = item.cmd[0];
               slave_in    = item.cmd[0] ? (item.address | 8'h01)
                                         : (item.address & i2cm_pkg::ADDR_WR_MASK);
               xfer_len_in = (int'(item.length) > BUF_DEPTH) ? 6'(BUF_DEPTH)
                                                             : item.length;
               byte_pos_in = '0;
               if (attempt_limit == '0) begin
                  attempts_in = '0;
                  fin         = 1'b1;
                  fin_code    = i2cm_pkg::RES_EXHAUSTED;
               end else begin
                  attempts_in      = attempt_limit - 8'd1;
                  phase_in         = i2cm_pkg::PH_START;
                  step.rsp.bus_op  = i2cm_pkg::OP_START;
               end
            end
         end
         default: begin
            unique case (phase_ff)
               i2cm_pkg::PH_START: begin
                  phase_in         = i2cm_pkg::PH_ADDR;
                  step.rsp.bus_op  = i2cm_pkg::OP_ADDR;
                  step.rsp.tx_byte = slave_ff;
               end
               i2cm_pkg::PH_ADDR: begin
                  if (item.event_req == i2cm_pkg::EV_ADDR_NACK) begin
                     fin      = 1'b1;
                     fin_stop = 1'b1;
                     fin_code = i2cm_pkg::RES_NO_SLAVE;
                  end else if (item.event_req != i2cm_pkg::EV_ADDR_ACK) begin
                     do_retry = 1'b1;
                  end else begin
                     do_nread  = is_read_ff;
                     do_nwrite = !is_read_ff;
                  end
               end
               i2cm_pkg::PH_DATA: begin
                  if (item.event_req == i2cm_pkg::EV_DATA_ACK) begin
                     next_pos    = byte_pos_ff + 6'd1;
                     byte_pos_in = next_pos;
                     do_nwrite   = 1'b1;
                  end else begin
                     do_retry = 1'b1;
                  end
               end
               i2cm_pkg::PH_RX: begin
                  step.rsp.store_valid = 1'b1;
                  step.rsp.store_index = byte_pos_ff[4:0];
                  step.rsp.store_byte  = item.rx_byte;
                  if (item.event_req == i2cm_pkg::EV_DATA_ACK) begin
                     next_pos    = byte_pos_ff + 6'd1;
                     byte_pos_in = next_pos;
                     do_nread    = 1'b1;
                  end else begin
                     do_retry = 1'b1;
                  end
               end
               i2cm_pkg::PH_LAST: begin
                  step.rsp.store_valid = 1'b1;
                  step.rsp.store_index = byte_pos_ff[4:0];
                  step.rsp.store_byte  = item.rx_byte;
                  fin      = 1'b1;
                  fin_stop = !arb;
               end
               default: begin
               end
            endcase
         end
      endcase

      if (do_retry) begin
         if (attempts_ff == '0) begin
            fin      = 1'b1;
            fin_stop = !arb;
            fin_code = i2cm_pkg::RES_EXHAUSTED;
         end else begin
            attempts_in     = attempts_ff - 8'd1;
            byte_pos_in     = '0;
            phase_in        = i2cm_pkg::PH_START;
            step.rsp.bus_op = i2cm_pkg::OP_START;
         end
      end

      if (do_nread) begin
         if ({1'b0, xfer_len_ff} > ({1'b0, next_pos} + 7'd1)) begin
            phase_in        = i2cm_pkg::PH_RX;
            step.rsp.bus_op = i2cm_pkg::OP_RXACK;
         end else begin
            phase_in        = i2cm_pkg::PH_LAST;
            step.rsp.bus_op = i2cm_pkg::OP_RXNACK;
         end
      end

      if (do_nwrite) begin
         if ((next_pos < xfer_len_ff) && (int'(next_pos) < BUF_DEPTH)) begin
            phase_in        = i2cm_pkg::PH_DATA;
            step.rsp.bus_op = i2cm_pkg::OP_DATA;
            step.use_buf    = 1'b1;
            buf_rd_en       = adv;
         end else begin
            fin      = 1'b1;
            fin_stop = 1'b1;
         end
      end

      if (fin) begin
         phase_in             = i2cm_pkg::PH_IDLE;
         step.rsp.bus_op      = fin_stop ? i2cm_pkg::OP_STOP : i2cm_pkg::OP_NONE;
         step.rsp.done_res    = 1'b1;
         step.rsp.result_code = fin_code;
      end
   end

   assign buf_wr_addr = li_ext[AW-1:0];
   assign buf_rd_addr = pos_ext[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= i2cm_pkg::PH_IDLE;
         is_read_ff  <= 1'b0;
         slave_ff    <= '0;
         xfer_len_ff <= '0;
         byte_pos_ff <= '0;
         attempts_ff <= '0;
      end else if (adv) begin
         phase_ff    <= phase_in;
         is_read_ff  <= is_read_in;
         slave_ff    <= slave_in;
         xfer_len_ff <= xfer_len_in;
         byte_pos_ff <= byte_pos_in;
         attempts_ff <= attempts_in;
      end
   end

endmodule

// ===== rtl/core/i2c_master_transaction_sequencer.sv =====
// ----------------------------------------------------------------------------
// I2C master transaction sequencer
// Turns requests, buffer loads and bus events into the next bus operation.
//
//   channel | ports           | beat
//   --------+-----------------+------------------------------------------
//   req     | req_valid/ready | command, address, length, event, rx/load
//   rsp     | rsp_valid/ready | bus op, tx byte, store, done and result
//   csr     | psel .. pready  | attempt_limit at byte address 0
//
// One beat per cycle sustained while the result side takes beats; each beat
// passes through the input register and then the result register.
// The write buffer read is registered alongside the result register.
// Reset clears the transfer state and valid flags; buffer contents are kept.
// A stalled result holds in place; the input register drains into it as
// soon as it is taken, so req_ready only drops while both stages are full.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer #(
   parameter int BUF_DEPTH = i2cm_pkg::BUF_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  i2cm_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output i2cm_pkg::rsp_type               rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [i2cm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

   logic              in_valid_ff;
   i2cm_pkg::req_type in_ff;
   logic              rsp_valid_ff;
   i2cm_pkg::rsp_type rsp_ff;
   logic              use_buf_ff;
   logic [7:0]        limit_ff;

   logic               adv;
   i2cm_pkg::step_type step;
   logic               buf_wr_en, buf_rd_en;
   logic [AW-1:0]      buf_wr_addr, buf_rd_addr;
   logic [7:0]         buf_rd_data;

   assign adv       = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || adv;

   // register port
   assign pready = 1'b1;
   assign prdata = (paddr == i2cm_pkg::CSR_ATTEMPT_LIMIT) ? {24'd0, limit_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= i2cm_pkg::ATTEMPT_LIMIT_RST;
      end else if (psel && penable && pwrite && pready &&
                   (paddr == i2cm_pkg::CSR_ATTEMPT_LIMIT)) begin
         limit_ff <= pwdata[7:0];
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   i2cm_ctrl #(
      .BUF_DEPTH (BUF_DEPTH),
      .AW        (AW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .item          (in_ff),
      .attempt_limit (limit_ff),
      .step          (step),
      .buf_wr_en     (buf_wr_en),
      .buf_wr_addr   (buf_wr_addr),
      .buf_rd_en     (buf_rd_en),
      .buf_rd_addr   (buf_rd_addr)
   );

   i2cm_wbuf #(
      .DEPTH (BUF_DEPTH),
      .AW    (AW)
   ) u_wbuf (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (buf_wr_addr),
      .wr_data (in_ff.load_byte),
      .rd_en   (buf_rd_en),
      .rd_addr (buf_rd_addr),
      .rd_data (buf_rd_data)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (adv) begin
         rsp_ff     <= step.rsp;
         use_buf_ff <= step.use_buf;
      end
   end

   always_comb begin
      rsp_data = rsp_ff;
      if (use_buf_ff) begin
         rsp_data.tx_byte = buf_rd_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/i2cm_chk.sv =====
// ----------------------------------------------------------------------------
// I2C master sequencer checker
// Port-level checks on result beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "i2c_master_transaction_sequencer_assert.svh"

module i2cm_chk (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input i2cm_pkg::rsp_type rsp_data
);

   // a finished transfer only ever closes with stop or nothing
   `I2CM_ASSERT_NOW(a_done_op, clock, reset, rsp_valid && rsp_data.done_res, (rsp_data.bus_op == i2cm_pkg::OP_STOP) || (rsp_data.bus_op == i2cm_pkg::OP_NONE), "done beat with a bus operation other than stop or none")

   // result code stays clear and no stop is issued when not done
   `I2CM_ASSERT_NOW(a_code_clear, clock, reset, rsp_valid && !rsp_data.done_res, (rsp_data.result_code == i2cm_pkg::RES_OK) && (rsp_data.bus_op != i2cm_pkg::OP_STOP || rsp_data.done_res), "result code set without done")

   `I2CM_ASSERT_NOW(a_tx_clear, clock, reset, rsp_valid && (rsp_data.bus_op != i2cm_pkg::OP_ADDR) && (rsp_data.bus_op != i2cm_pkg::OP_DATA), rsp_data.tx_byte == 8'd0, "tx byte set on an operation that sends nothing")

   // stalled result beat holds
   `I2CM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result beat changed")

endmodule

bind i2c_master_transaction_sequencer i2cm_chk u_i2cm_chk (.*);
